>>> sv/hdts_pkg.sv
// hdts_pkg: types, constants and character class functions for the
// hex digest token scanner; no dependencies
`default_nettype none

package hdts_pkg;

   localparam int WORDS      = 4;
   localparam int WORD_W     = 64;
   localparam int CAP_W      = WORDS * WORD_W;
   localparam int RUN_W      = 7;
   localparam int NIB_IDX_W  = 6;
   localparam int IDX_W      = 2;

   typedef logic [RUN_W-1:0]     run_type;
   typedef logic [CAP_W-1:0]     capture_type;
   typedef logic [IDX_W-1:0]     index_type;

   localparam run_type   RUN_MAX  = 7'd127;
   localparam index_type LAST_IDX = 2'd3;

   typedef struct packed {
      logic        found;
      capture_type digest;
   } report_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_hex(input logic [7:0] b);
      return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) ||
             ((b >= 8'h41) && (b <= 8'h46));
   endfunction

   function automatic logic is_alnum(input logic [7:0] b);
      return is_digit(b) || ((b >= 8'h41) && (b <= 8'h5a)) ||
             ((b >= 8'h61) && (b <= 8'h7a));
   endfunction

   // valid only for hex characters; letters have a low nibble of 1 to 6
   function automatic logic [3:0] hex_value(input logic [7:0] b);
      return b[6] ? (b[3:0] + 4'd9) : b[3:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/hdts_scan.sv
// hdts_scan: run tracking and digit capture state for the scanner
// depends on hdts_pkg
`default_nettype none

module hdts_scan
   import hdts_pkg::*;
#(
   parameter int DIGEST_DIGITS = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] text_byte,
   input  wire logic       end_of_text,
   output report_type      report
);

   localparam run_type DIGITS = run_type'(DIGEST_DIGITS);

   logic        prev_alnum_ff, prev_alnum_in;
   run_type     run_length_ff, run_length_in;
   logic        left_ok_ff, left_ok_in;
   capture_type capture_ff, capture_in;
   logic        match_ff, match_in;

   logic                 hit;
   logic                 alnum;
   logic [NIB_IDX_W-1:0] nib;
   logic                 final_match;

   always_comb begin
      hit           = is_hex(text_byte);
      alnum         = is_alnum(text_byte);
      nib           = NIB_IDX_W'(6'd63 - run_length_ff[NIB_IDX_W-1:0]);
      prev_alnum_in = alnum;
      run_length_in = run_length_ff;
      left_ok_in    = left_ok_ff;
      capture_in    = capture_ff;
      match_in      = match_ff;
      if (!match_ff) begin
         if (hit) begin
            if (run_length_ff == '0) begin
               left_ok_in = !prev_alnum_ff;
               capture_in = '0;
            end
            if (run_length_ff < DIGITS) begin
               capture_in[{nib, 2'b00} +: 4] = hex_value(text_byte);
            end
            if (run_length_ff != RUN_MAX) begin
               run_length_in = run_length_ff + 7'd1;
            end
         end else begin
            if ((run_length_ff == DIGITS) && left_ok_ff && !alnum) begin
               match_in = 1'b1;
            end
            run_length_in = '0;
         end
      end
      final_match   = match_in || ((run_length_in == DIGITS) && left_ok_in);
      report.found  = final_match;
      report.digest = final_match ? capture_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_text)) begin
         prev_alnum_ff <= 1'b0;
         run_length_ff <= '0;
         left_ok_ff    <= 1'b0;
         capture_ff    <= '0;
         match_ff      <= 1'b0;
      end else if (step) begin
         prev_alnum_ff <= prev_alnum_in;
         run_length_ff <= run_length_in;
         left_ok_ff    <= left_ok_in;
         capture_ff    <= capture_in;
         match_ff      <= match_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/hex_digest_token_scanner.sv
// hex_digest_token_scanner: top level, input register, scanner and report buffer
// depends on hdts_pkg and hdts_scan
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    text_byte, end_of_text
//   rsp      out        rsp_valid/stall    found, digest_word, word_index, last_word
//
// one byte per cycle sustained unless a final byte waits; bytes pass the input register
// the final byte of a text gives one or four transactions, one per cycle while
// rsp_stall is low, from the report buffer; a final byte waits in the input
// register until the previous report has drained, other bytes pass regardless of rsp_stall
// reset is synchronous and clears all scan state; each final byte also does
`default_nettype none

module hex_digest_token_scanner
   import hdts_pkg::*;
#(
   parameter int DIGEST_DIGITS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_text_byte,
   input  wire logic              req_end_of_text,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_found,
   output logic [WORD_W-1:0]      rsp_digest_word,
   output logic [IDX_W-1:0]       rsp_word_index,
   output logic                   rsp_last_word
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_eot_ff;

   logic        rpt_valid_ff;
   logic        rpt_found_ff;
   capture_type rpt_words_ff;
   index_type   rpt_idx_ff;

   logic        consume;
   logic        rsp_accept;
   logic        rsp_last;
   logic        rpt_free;
   logic        rpt_load;
   report_type  report;

   hdts_scan #(
      .DIGEST_DIGITS(DIGEST_DIGITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (consume),
      .text_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .report      (report)
   );

   assign rsp_last   = !rpt_found_ff || (rpt_idx_ff == LAST_IDX);
   assign rsp_accept = rpt_valid_ff && !rsp_stall;
   assign rpt_free   = !rpt_valid_ff || (rsp_accept && rsp_last);
   assign consume    = in_valid_ff && (!in_eot_ff || rpt_free);
   assign rpt_load   = consume && in_eot_ff;
   assign req_stall  = in_valid_ff && !consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (consume) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_text_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpt_valid_ff <= 1'b0;
         rpt_idx_ff   <= '0;
      end else if (rpt_load) begin
         rpt_valid_ff <= 1'b1;
         rpt_idx_ff   <= '0;
      end else if (rsp_accept) begin
         if (rsp_last) begin
            rpt_valid_ff <= 1'b0;
         end else begin
            rpt_idx_ff <= rpt_idx_ff + 2'd1;
         end
      end
      if (rpt_load) begin
         rpt_found_ff <= report.found;
         rpt_words_ff <= report.digest;
      end else if (rsp_accept) begin
         rpt_words_ff <= {rpt_words_ff[CAP_W-WORD_W-1:0], {WORD_W{1'b0}}};
      end
   end

   assign rsp_valid       = rpt_valid_ff;
   assign rsp_found       = rpt_found_ff;
   assign rsp_digest_word = rpt_words_ff[CAP_W-1 -: WORD_W];
   assign rsp_word_index  = rpt_idx_ff;
   assign rsp_last_word   = rsp_last;

endmodule

`default_nettype wire

>>> sv/hdts_checker.sv
// hdts_checker: port level assertions for the scanner, bound to the top level
// depends on hdts_pkg
`default_nettype none

module hdts_checker
   import hdts_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic              rsp_found,
   input wire logic [WORD_W-1:0] rsp_digest_word,
   input wire logic [IDX_W-1:0]  rsp_word_index,
   input wire logic              rsp_last_word
);

   // a no-match report is a single zero transaction
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
         rsp_last_word && (rsp_word_index == '0) && (rsp_digest_word == '0))
      else $error("no-match report malformed");

   // a match report ends exactly on its last word
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_last_word == (rsp_word_index == LAST_IDX)))
      else $error("last_word out of step with word_index");

   // words of a match report follow one another without a gap
   a_next_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_found && !rsp_last_word |=>
         rsp_valid && rsp_found &&
         (rsp_word_index == $past(rsp_word_index) + 2'd1))
      else $error("digest words not consecutive");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index))
      else $error("stalled transaction changed");

endmodule

bind hex_digest_token_scanner hdts_checker u_hdts_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_found       (rsp_found),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench for hex_digest_token_scanner, a scoreboard class
// that predicts the digest report per text, with tasks that build and send texts
// depends on hdts_pkg and hex_digest_token_scanner
`timescale 1ns / 1ps

module tb_top;
   import hdts_pkg::*;

   localparam int TOKEN_DIGITS = 64;

   typedef struct {
      logic              found;
      logic [WORD_W-1:0] word;
      logic [IDX_W-1:0]  idx;
      logic              last;
   } digest_word_type;

   typedef enum int {
      SK_NOISE, SK_TOKEN, SK_LEFT_BAD, SK_RIGHT_BAD, SK_NEAR, SK_LONG, SK_TWO, SK_LATE,
      SK_COUNT
   } stream_kind_type;

   function automatic bit word_char(logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
             (b >= 8'h61 && b <= 8'h7a);
   endfunction

   function automatic int digit_value(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 48;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 97 + 10;
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 65 + 10;
      return -1;
   endfunction

   class digest_scoreboard_type;
      bit                prev_word_char;
      logic [6:0]        run_len;
      bit                left_ok;
      logic [255:0]      digits;
      bit                matched;
      digest_word_type   expected_words[$];
      int                errors;

      function new();
         clear_scan();
         errors = 0;
      endfunction

      function void clear_scan();
         prev_word_char = 0;
         run_len = '0;
         left_ok = 0;
         digits = '0;
         matched = 0;
      endfunction

      function void note_byte(logic [7:0] b, logic eot);
         int hv;
         bit wc;
         digest_word_type e;
         hv = digit_value(b);
         wc = word_char(b);
         if (!matched) begin
            if (hv >= 0) begin
               if (run_len == 0) begin
                  left_ok = !prev_word_char;
                  digits = '0;
               end
               if (run_len < TOKEN_DIGITS)
                  digits[255 - 4 * run_len -: 4] = hv[3:0];
               if (run_len < RUN_MAX)
                  run_len = run_len + 7'd1;
            end else begin
               if (run_len == TOKEN_DIGITS && left_ok && !wc)
                  matched = 1;
               run_len = '0;
            end
         end
         prev_word_char = wc;
         if (!eot)
            return;
         // the end of the text is a valid right edge
         if (!matched && run_len == TOKEN_DIGITS && left_ok)
            matched = 1;
         if (matched) begin
            for (int w = 0; w < WORDS; w++) begin
               e.found = 1'b1;
               e.word = digits[255 - 64 * w -: 64];
               e.idx = IDX_W'(w);
               e.last = (w == WORDS - 1);
               expected_words = {expected_words, e};
            end
         end else begin
            e.found = 1'b0;
            e.word = '0;
            e.idx = '0;
            e.last = 1'b1;
            expected_words = {expected_words, e};
         end
         clear_scan();
      endfunction

      function void check_word(logic found, logic [WORD_W-1:0] word, logic [IDX_W-1:0] idx,
                               logic last);
         digest_word_type e;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected transaction found=%0b word=%h idx=%0d last=%0b",
                     $time, found, word, idx, last);
            errors++;
            return;
         end
         e = expected_words.pop_front();
         if (found !== e.found) begin
            $display("%0t: found expected %0b actual %0b", $time, e.found, found);
            errors++;
         end
         if (word !== e.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, e.word, word);
            errors++;
         end
         if (idx !== e.idx) begin
            $display("%0t: word_index expected %0d actual %0d", $time, e.idx, idx);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last_word expected %0b actual %0b", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_text_byte = 8'h00;
   logic              req_end_of_text = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_found;
   logic [WORD_W-1:0] rsp_digest_word;
   logic [IDX_W-1:0]  rsp_word_index;
   logic              rsp_last_word;

   bit                     steady = 1'b0;
   logic [7:0]             text_q[$];
   digest_scoreboard_type  sb;

   logic [7:0] singles [14] = '{8'h00, 8'hff, 8'h30, 8'h39, 8'h61, 8'h66, 8'h41, 8'h46,
                                8'h47, 8'h5a, 8'h7a, 8'h20, 8'h7f, 8'h80};

   hex_digest_token_scanner #(.DIGEST_DIGITS(TOKEN_DIGITS)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_found, rsp_digest_word, rsp_word_index, rsp_last_word);
      rsp_stall <= steady ? 1'b0 : ($urandom_range(99) < 26);
   end

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(15);
      if (v < 10) return 8'(48 + v);
      return 8'(($urandom_range(1) ? 97 : 65) + v - 10);
   endfunction

   function automatic logic [7:0] sep_char();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (word_char(b));
      return b;
   endfunction

   // letters outside a-f, so they break a run without extending it
   function automatic logic [7:0] plain_letter();
      return 8'(($urandom_range(1) ? 103 : 71) + $urandom_range(19));
   endfunction

   task automatic add_byte(input logic [7:0] b);
      text_q = {text_q, b};
   endtask

   task automatic push_run(input int n);
      repeat (n) add_byte(hex_char());
   endtask

   task automatic push_noise(input int n);
      repeat (n) add_byte(8'($urandom_range(255)));
   endtask

   task automatic build_text(input int kind);
      int len;
      text_q.delete();
      if (kind == SK_NOISE) begin
         push_noise($urandom_range(1, 30));
      end else begin
         if (kind == SK_LEFT_BAD) begin
            push_noise($urandom_range(0, 4));
            add_byte(plain_letter());
         end else if ($urandom_range(1)) begin
            push_noise($urandom_range(0, 6));
            add_byte(sep_char());
         end
         if (kind == SK_LATE) begin
            case ($urandom_range(2))
               0: push_run(TOKEN_DIGITS - 1);
               1: push_run(TOKEN_DIGITS + 1);
               default: push_run($urandom_range(128, 140));
            endcase
            add_byte(sep_char());
         end
         if (kind == SK_NEAR)
            len = $urandom_range(1) ? TOKEN_DIGITS - 1 : TOKEN_DIGITS + 1;
         else if (kind == SK_LONG)
            len = $urandom_range(100, 140);
         else
            len = TOKEN_DIGITS;
         push_run(len);
         if (kind == SK_RIGHT_BAD) begin
            add_byte(plain_letter());
            push_noise($urandom_range(0, 4));
         end else if (kind == SK_TWO) begin
            add_byte(sep_char());
            push_run(TOKEN_DIGITS);
            if ($urandom_range(1)) add_byte(sep_char());
         end else if ($urandom_range(1)) begin
            add_byte(sep_char());
            push_noise($urandom_range(0, 6));
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eot);
      while (!steady && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, eot);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   function automatic int pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 40) return SK_TOKEN;
      if (r < 50) return SK_TWO;
      if (r < 58) return SK_LATE;
      if (r < 66) return SK_LEFT_BAD;
      if (r < 74) return SK_RIGHT_BAD;
      if (r < 82) return SK_NEAR;
      if (r < 90) return SK_LONG;
      return SK_NOISE;
   endfunction

   initial begin
      int n_texts;
      int n_bytes;
      int spins;
      sb = new();
      n_texts = 0;
      n_bytes = 0;
      spins = 0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // one-byte texts, then a short run ending the text
      foreach (singles[i])
         send_byte(singles[i], 1'b1);
      send_byte(8'h20, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h30, 1'b1);
      n_bytes = 17;

      // kinds in order, then weighted towards well-formed tokens
      while (n_bytes < 420) begin
         steady <= (n_bytes >= 150 && n_bytes < 300);
         build_text(n_texts < SK_COUNT ? n_texts : pick_kind());
         send_text();
         n_bytes += text_q.size();
         n_texts++;
      end
      req_valid <= 1'b0;
      steady <= 1'b0;

      while (sb.expected_words.size() != 0 && spins < 2000) begin
         @(posedge clock);
         spins++;
      end
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.expected_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
